// ----- rtl/altilt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the accelerometer low-pass tilt angle block.
// Holds shared constants, register indexes and the CORDIC arctangent table.
package altilt_pkg;

	localparam int ACCEL_WIDTH_DEF      = 16;
	localparam int ANGLE_ITERATIONS_DEF = 16;
	localparam int TIME_W               = 63;
	localparam int TAU_W                = 32;
	localparam int FILT_W               = 32;
	localparam int NORM_BITS            = 15;
	localparam int ANGLE_W              = 16;
	localparam int CFG_INDEX_W          = 3;
	localparam int CFG_DATA_W           = 32;

	localparam logic [TAU_W-1:0] TAU_RESET    = 32'd250000000;
	localparam int               GREF_Z_RESET = 10043;
	localparam logic [31:0]      DEG90        = 32'd5898240;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 16'd46080;

	localparam logic [CFG_INDEX_W-1:0] REG_TAU    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GREF_X = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GREF_Y = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GREF_Z = 3'd3;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [21:0] atan_of(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/altilt_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tilt angle block.
// Sample channel carries timestamp and acceleration; result channel the angle.
interface altilt_in_if #(parameter int ACCEL_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic [62:0]                   sample_time_ns;
	logic signed [ACCEL_WIDTH-1:0] accel_x;
	logic signed [ACCEL_WIDTH-1:0] accel_y;
	logic signed [ACCEL_WIDTH-1:0] accel_z;
	modport source(output valid, sample_time_ns, accel_x, accel_y, accel_z, input ready);
	modport sink(input valid, sample_time_ns, accel_x, accel_y, accel_z, output ready);
endinterface

interface altilt_out_if #(parameter int ACCEL_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic [15:0]                   tilt_angle;
	logic                          degenerate;
	logic signed [ACCEL_WIDTH-1:0] smoothed_x;
	logic signed [ACCEL_WIDTH-1:0] smoothed_y;
	logic signed [ACCEL_WIDTH-1:0] smoothed_z;
	modport source(output valid, tilt_angle, degenerate, smoothed_x, smoothed_y, smoothed_z,
		input ready);
	modport sink(input valid, tilt_angle, degenerate, smoothed_x, smoothed_y, smoothed_z,
		output ready);
endinterface

// ----- rtl/accel_lowpass_tilt_angle.sv -----
`timescale 1ns / 1ps
// Top level of the accelerometer low-pass tilt angle block.
// Depends on altilt_pkg, altilt_if and altilt_isqrt.
//
// Usage:
//   sample: valid/ready channel with timestamp (ns) and signed Q5.10 x/y/z.
//   result: valid/ready channel with the tilt angle in 1/256 degree, the
//           degenerate flag and the filtered vector in Q5.10.
//   Config: write tau_ns and the gravity reference through cfg_we/cfg_index/
//           cfg_data while no item is in flight; unknown indexes are dropped.
// One item is worked on at a time. An accepted item goes through the serial
// alpha divider, the filter update, the serial bit-length count, the products
// on the shared multiplier, the two-bit-per-cycle square root, the CORDIC
// rotation and the final rounding. A degenerate item skips the angle work.
// The first item after reset seeds the filter directly and skips the divider
// and the filter update. The next item can be taken in the cycle after the
// result is loaded.
// sample.ready is high only while the sequencer is idle. The result waits in
// an output register; while the receiver stalls, the next item is still
// taken and worked, and holds in the last step until the register frees.
// Reset clears the filter, the seeded flag and the registers to defaults.
module accel_lowpass_tilt_angle #(
	parameter int ACCEL_WIDTH      = altilt_pkg::ACCEL_WIDTH_DEF,
	parameter int ANGLE_ITERATIONS = altilt_pkg::ANGLE_ITERATIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [altilt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [altilt_pkg::CFG_DATA_W-1:0]  cfg_data,
	altilt_in_if.sink                          sample,
	altilt_out_if.source                       result
);
	import altilt_pkg::*;

	localparam int FILT_FRAC = FILT_W - ACCEL_WIDTH;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DSET  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_LP    = 4'd3;
	localparam logic [3:0] S_CHECK = 4'd4;
	localparam logic [3:0] S_NORM  = 4'd5;
	localparam logic [3:0] S_SHIFT = 4'd6;
	localparam logic [3:0] S_PROD  = 4'd7;
	localparam logic [3:0] S_SQRT  = 4'd8;
	localparam logic [3:0] S_CORD  = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// block-normalize one component to NORM_BITS magnitude bits
	function automatic logic signed [15:0] norm_shift(input logic signed [31:0] v,
		input logic [5:0] bl);
		logic signed [31:0] r;
		if (bl > 6'(NORM_BITS)) r = v >>> (bl - 6'(NORM_BITS));
		else r = v <<< (6'(NORM_BITS) - bl);
		return r[15:0];
	endfunction

	function automatic logic signed [31:0] widen(input logic signed [ACCEL_WIDTH-1:0] v);
		return 32'(v);
	endfunction

	logic [3:0] state_q;
	logic [4:0] cnt_q;

	logic [TAU_W-1:0]              tau_q;
	logic signed [ACCEL_WIDTH-1:0] gref_q [3];
	logic [TIME_W-1:0]             prev_q, dt_q;
	logic                          seeded_q, dt_zero_q;

	logic signed [ACCEL_WIDTH-1:0] acc_q  [3];
	logic signed [FILT_W-1:0]      filt_q [3];

	logic [63:0] dvs_q;
	logic [64:0] rem_q;
	logic [16:0] quo_q, alpha_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p_q;

	logic [31:0] ma_q, mb_q;
	logic [5:0]  bla_q, blb_q;
	logic signed [15:0] na_q [3];
	logic signed [15:0] nb_q [3];

	logic signed [32:0] tmp_q, cx_q, cy_q, cz_q;
	logic signed [33:0] dot_q;
	logic [63:0]        ssq_q;

	logic signed [35:0] xc_q, yc_q;
	logic signed [31:0] zc_q;

	logic              degen_q;
	logic [ANGLE_W-1:0] angle_q;

	logic                          out_valid_q, out_degen_q;
	logic [ANGLE_W-1:0]            out_angle_q;
	logic signed [ACCEL_WIDTH-1:0] out_sm_q [3];

	logic        sqrt_start, sqrt_done;
	logic [31:0] sqrt_root;

	logic accept, out_free;
	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;
	assign sample.ready = (state_q == S_IDLE);

	// ------------------------------------------------------------------
	// Shared combinational pieces
	// ------------------------------------------------------------------
	logic [64:0] div_sh;
	logic        div_ge;
	assign div_sh = (cnt_q == 5'd0) ? rem_q : {rem_q[63:0], 1'b0};
	assign div_ge = div_sh >= {1'b0, dvs_q};

	logic signed [32:0] lp_diff;
	logic signed [31:0] lp_new;
	assign lp_diff = 33'(widen(acc_q[0]) <<< FILT_FRAC) - 33'(filt_q[0]);
	assign lp_new  = filt_q[0] + 32'(mul_p_q >>> 16);

	logic ref_zero, filt_zero;
	assign ref_zero  = (gref_q[0] == '0) && (gref_q[1] == '0) && (gref_q[2] == '0);
	assign filt_zero = (filt_q[0] == '0) && (filt_q[1] == '0) && (filt_q[2] == '0);

	logic signed [35:0] xs, ys;
	logic signed [31:0] at;
	assign xs = xc_q >>> cnt_q;
	assign ys = yc_q >>> cnt_q;
	assign at = 32'(atan_of(cnt_q));

	logic signed [31:0] z_rnd;
	assign z_rnd = (zc_q + 32'sd128) >>> 8;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_LP) begin
			mul_a = 34'(lp_diff);
			mul_b = $signed({17'd0, alpha_q});
		end else if (state_q == S_PROD) begin
			case (cnt_q)
				5'd0:  begin mul_a = 34'(na_q[1]); mul_b = 34'(nb_q[2]); end
				5'd1:  begin mul_a = 34'(na_q[2]); mul_b = 34'(nb_q[1]); end
				5'd2:  begin mul_a = 34'(na_q[2]); mul_b = 34'(nb_q[0]); end
				5'd3:  begin mul_a = 34'(na_q[0]); mul_b = 34'(nb_q[2]); end
				5'd4:  begin mul_a = 34'(na_q[0]); mul_b = 34'(nb_q[1]); end
				5'd5:  begin mul_a = 34'(na_q[1]); mul_b = 34'(nb_q[0]); end
				5'd6:  begin mul_a = 34'(na_q[0]); mul_b = 34'(nb_q[0]); end
				5'd7:  begin mul_a = 34'(na_q[1]); mul_b = 34'(nb_q[1]); end
				5'd8:  begin mul_a = 34'(na_q[2]); mul_b = 34'(nb_q[2]); end
				5'd9:  begin mul_a = 34'(cx_q);    mul_b = 34'(cx_q);    end
				5'd10: begin mul_a = 34'(cy_q);    mul_b = 34'(cy_q);    end
				5'd11: begin mul_a = 34'(cz_q);    mul_b = 34'(cz_q);    end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	// start once the last square has been added in
	assign sqrt_start = (state_q == S_PROD) && (cnt_q == 5'd13);

	altilt_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (ssq_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q     <= TAU_RESET;
			gref_q[0] <= '0;
			gref_q[1] <= '0;
			gref_q[2] <= ACCEL_WIDTH'(GREF_Z_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAU:    tau_q     <= cfg_data;
				REG_GREF_X: gref_q[0] <= cfg_data[ACCEL_WIDTH-1:0];
				REG_GREF_Y: gref_q[1] <= cfg_data[ACCEL_WIDTH-1:0];
				REG_GREF_Z: gref_q[2] <= cfg_data[ACCEL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			seeded_q    <= 1'b0;
			prev_q      <= '0;
			filt_q[0]   <= '0;
			filt_q[1]   <= '0;
			filt_q[2]   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready && !(state_q == S_DONE && out_free)) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_q   <= sample.sample_time_ns;
						seeded_q <= 1'b1;
						cnt_q    <= '0;
						if (!seeded_q) begin
							// first item loads the filter directly
							filt_q[0] <= widen(sample.accel_x) <<< FILT_FRAC;
							filt_q[1] <= widen(sample.accel_y) <<< FILT_FRAC;
							filt_q[2] <= widen(sample.accel_z) <<< FILT_FRAC;
							state_q   <= S_CHECK;
						end else begin
							state_q <= S_DSET;
						end
					end
				end
				S_DSET: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == 5'd16) begin
						cnt_q   <= '0;
						state_q <= S_LP;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_LP: begin
					if (cnt_q[0]) begin
						// rotate the axes so the next one sits at the head
						filt_q[0] <= filt_q[1];
						filt_q[1] <= filt_q[2];
						filt_q[2] <= lp_new;
					end
					if (cnt_q == 5'd5) begin
						cnt_q   <= '0;
						state_q <= S_CHECK;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_CHECK: state_q <= (ref_zero || filt_zero) ? S_DONE : S_NORM;
				S_NORM: if (ma_q == '0 && mb_q == '0) state_q <= S_SHIFT;
				S_SHIFT: begin
					cnt_q   <= '0;
					state_q <= S_PROD;
				end
				S_PROD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd13) state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= '0;
					if (sqrt_done) state_q <= S_CORD;
				end
				S_CORD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ANGLE_ITERATIONS - 1)) state_q <= S_FIN;
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					acc_q[0]  <= sample.accel_x;
					acc_q[1]  <= sample.accel_y;
					acc_q[2]  <= sample.accel_z;
					dt_zero_q <= !(sample.sample_time_ns > prev_q);
					dt_q      <= (sample.sample_time_ns > prev_q) ?
						sample.sample_time_ns - prev_q : '0;
				end
			end
			S_DSET: begin
				dvs_q <= {32'd0, tau_q} + {1'b0, dt_q};
				rem_q <= {2'b00, dt_q};
				quo_q <= '0;
			end
			S_DIV: begin
				// restoring division, one quotient bit per cycle
				rem_q <= div_ge ? 65'(div_sh - {1'b0, dvs_q}) : div_sh;
				quo_q <= {quo_q[15:0], div_ge};
				if (cnt_q == 5'd16) alpha_q <= dt_zero_q ? '0 : {quo_q[15:0], div_ge};
			end
			S_LP: begin
				if (cnt_q[0]) begin
					acc_q[0] <= acc_q[1];
					acc_q[1] <= acc_q[2];
					acc_q[2] <= acc_q[0];
				end
			end
			S_CHECK: begin
				degen_q <= ref_zero || filt_zero;
				angle_q <= '0;
				ma_q    <= mag32(widen(gref_q[0])) | mag32(widen(gref_q[1])) |
					mag32(widen(gref_q[2]));
				mb_q    <= mag32(filt_q[0]) | mag32(filt_q[1]) | mag32(filt_q[2]);
				bla_q   <= '0;
				blb_q   <= '0;
			end
			S_NORM: begin
				// bit length of the largest magnitude, one bit per cycle
				if (ma_q != '0) begin
					ma_q  <= ma_q >> 1;
					bla_q <= bla_q + 6'd1;
				end
				if (mb_q != '0) begin
					mb_q  <= mb_q >> 1;
					blb_q <= blb_q + 6'd1;
				end
			end
			S_SHIFT: begin
				na_q[0] <= norm_shift(widen(gref_q[0]), bla_q);
				na_q[1] <= norm_shift(widen(gref_q[1]), bla_q);
				na_q[2] <= norm_shift(widen(gref_q[2]), bla_q);
				nb_q[0] <= norm_shift(filt_q[0], blb_q);
				nb_q[1] <= norm_shift(filt_q[1], blb_q);
				nb_q[2] <= norm_shift(filt_q[2], blb_q);
			end
			S_PROD: begin
				// products land in the cycle after their operands
				case (cnt_q)
					5'd1, 5'd3, 5'd5: tmp_q <= 33'(mul_p_q);
					5'd2:  cx_q  <= tmp_q - 33'(mul_p_q);
					5'd4:  cy_q  <= tmp_q - 33'(mul_p_q);
					5'd6:  cz_q  <= tmp_q - 33'(mul_p_q);
					5'd7:  dot_q <= 34'(mul_p_q);
					5'd8, 5'd9: dot_q <= dot_q + 34'(mul_p_q);
					5'd10: ssq_q <= mul_p_q[63:0];
					5'd11, 5'd12: ssq_q <= ssq_q + mul_p_q[63:0];
					default: ;
				endcase
			end
			S_SQRT: begin
				if (sqrt_done) begin
					if (dot_q < 0) begin
						xc_q <= $signed({4'd0, sqrt_root});
						yc_q <= -36'(dot_q);
						zc_q <= $signed(DEG90);
					end else begin
						xc_q <= 36'(dot_q);
						yc_q <= $signed({4'd0, sqrt_root});
						zc_q <= '0;
					end
				end
			end
			S_CORD: begin
				if (yc_q > 0) begin
					xc_q <= xc_q + ys;
					yc_q <= yc_q - xs;
					zc_q <= zc_q + at;
				end else begin
					xc_q <= xc_q - ys;
					yc_q <= yc_q + xs;
					zc_q <= zc_q - at;
				end
			end
			S_FIN: begin
				if (z_rnd < 0) angle_q <= '0;
				else if (z_rnd > $signed({16'd0, ANGLE_MAX})) angle_q <= ANGLE_MAX;
				else angle_q <= z_rnd[ANGLE_W-1:0];
			end
			S_DONE: begin
				if (out_free) begin
					out_angle_q <= angle_q;
					out_degen_q <= degen_q;
					out_sm_q[0] <= ACCEL_WIDTH'(filt_q[0] >>> FILT_FRAC);
					out_sm_q[1] <= ACCEL_WIDTH'(filt_q[1] >>> FILT_FRAC);
					out_sm_q[2] <= ACCEL_WIDTH'(filt_q[2] >>> FILT_FRAC);
				end
			end
			default: ;
		endcase
	end

	assign result.valid      = out_valid_q;
	assign result.tilt_angle = out_angle_q;
	assign result.degenerate = out_degen_q;
	assign result.smoothed_x = out_sm_q[0];
	assign result.smoothed_y = out_sm_q[1];
	assign result.smoothed_z = out_sm_q[2];
endmodule

// ----- rtl/altilt_isqrt.sv -----
`timescale 1ns / 1ps
// Digit-serial floor square root of a 64-bit value, two radicand bits per cycle.
// Uses no package items.
module altilt_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [63:0] src_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rem_sh, trial;
	logic        take;

	assign rem_sh = {rem_q, src_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			src_q <= {src_q[61:0], 2'b00};
			if (take) begin
				rem_q  <= 34'(rem_sh - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
